/* rtl/fafbc_pkg.sv */
// ----------------------------------------------------------------------------
// fafbc_pkg
// Shared types and constants of the frame-aged fetch buffer cache.
// ----------------------------------------------------------------------------
package fafbc_pkg;

  localparam int NumBuffers  = 32;
  localparam int BufferBytes = 2048;
  localparam int IdxW        = $clog2(NumBuffers);
  localparam int LinkW       = IdxW + 1;
  localparam int OffW        = $clog2(BufferBytes);
  localparam int AddrW       = 31;
  localparam int LenW        = 16;
  localparam int FrameW      = 32;
  localparam int CntW        = $clog2(NumBuffers + 1);

  // link value with the top bit set means no entry
  localparam logic [LinkW-1:0] Nil = {LinkW{1'b1}};

  typedef enum logic [1:0] {
    StatHit    = 2'd0,
    StatMiss   = 2'd1,
    StatFull   = 2'd2,
    StatTick   = 2'd3
  } status_e;

  typedef enum logic {
    OpLookup = 1'b0,
    OpTick   = 1'b1
  } op_e;

  typedef struct packed {
    logic             operation;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       buffer_index;
    logic [10:0]      byte_offset;
    logic             fetch_start;
    logic [AddrW-1:0] fetch_address;
    logic [7:0]       fetch_slot;
    logic [5:0]       freed_count;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start walk at used head
    logic step;      // evaluate current entry, advance
    logic lk_hit;    // finish lookup as hit
    logic lk_miss;   // finish lookup as miss
    logic lk_full;   // finish lookup with no free buffer
    logic tick_done; // finish tick
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic walk_end;  // no current entry or guard reached
    logic stop;      // current entry start beyond address
    logic hit;       // current entry covers the request
    logic free_ok;   // free list not empty
  } stat_t;

endpackage

/* rtl/frame_aged_fetch_buffer_cache.sv */
// ----------------------------------------------------------------------------
// frame_aged_fetch_buffer_cache
// Fetch buffer pool with sorted in-use list and frame-based aging.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The in-use list is
// walked one entry per cycle: a lookup passes over entries until it hits or
// finishes, and a tick walks every in-use entry.
// The result shows for one cycle with
// result_valid_o and busy falls the cycle after; the receiver cannot stall.
module frame_aged_fetch_buffer_cache
  import fafbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_word_t   req_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       result_valid_o,
  output out_word_t  result_o
);

  cmd_t  cmd;
  stat_t stat;

  fafbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fafbc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_strobe_o (result_valid_o),
    .res_o        (result_o)
  );

endmodule

/* rtl/fafbc_ctrl.sv */
// ----------------------------------------------------------------------------
// fafbc_ctrl
// Sequencer: walks the in-use list one entry per cycle, then finishes.
// ----------------------------------------------------------------------------
module fafbc_ctrl
  import fafbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (stat_i.is_tick) begin
          if (stat_i.walk_end) begin
            cmd_o.tick_done = 1'b1;
            state_d         = StDone;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else if (!stat_i.walk_end && !stat_i.stop && stat_i.hit) begin
          cmd_o.lk_hit = 1'b1;
          state_d      = StDone;
        end else if (stat_i.walk_end || stat_i.stop) begin
          if (stat_i.free_ok) cmd_o.lk_miss = 1'b1;
          else cmd_o.lk_full = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_one_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.lk_hit, cmd_o.lk_miss, cmd_o.lk_full, cmd_o.tick_done}))
    else $error("more than one finish command");
  a_finish_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.lk_hit || cmd_o.lk_miss || cmd_o.lk_full || cmd_o.tick_done)
      |=> state_q == StDone)
    else $error("finish without done state");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle)
    else $error("load while busy");
`endif

endmodule

/* rtl/fafbc_dp.sv */
// ----------------------------------------------------------------------------
// fafbc_dp
// Datapath: buffer tables, list links, counters and result register.
// ----------------------------------------------------------------------------
module fafbc_dp
  import fafbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  req_i,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output logic      res_strobe_o,
  output out_word_t res_o
);

  logic [AddrW-1:0]  start_q  [NumBuffers];
  logic [FrameW-1:0] last_q   [NumBuffers];
  logic [LinkW-1:0]  next_q   [NumBuffers];
  logic [LinkW-1:0]  prev_q   [NumBuffers];
  logic [LinkW-1:0]  used_head_q, free_head_q;
  logic [FrameW-1:0] frame_q;
  logic [7:0]        fetch_cnt_q;
  logic [7:0]        keep_q;

  in_word_t          req_q;
  logic [LinkW-1:0]  cur_q, last_vis_q;
  logic [CntW-1:0]   guard_q, freed_q;
  logic              strobe_q;
  out_word_t         res_q;
  out_word_t         res_d;
  logic              finish;

  logic [IdxW-1:0]   cur, fh;
  logic [AddrW:0]    req_end, buf_end;
  logic [FrameW-1:0] limit;
  logic              aged;
  logic [LinkW-1:0]  nxt;

  assign cur     = cur_q[IdxW-1:0];
  assign fh      = free_head_q[IdxW-1:0];
  assign nxt     = next_q[cur];
  assign req_end = {1'b0, req_q.address} + {{(AddrW+1-LenW){1'b0}}, req_q.length};
  assign buf_end = {1'b0, start_q[cur]} + (AddrW+1)'(BufferBytes);
  assign limit   = last_q[cur] + {{(FrameW-8){1'b0}}, keep_q};
  assign aged    = limit < frame_q;

  assign stat_o.is_tick  = req_q.operation;
  assign stat_o.walk_end = cur_q[IdxW] || (guard_q == CntW'(NumBuffers));
  assign stat_o.stop     = start_q[cur] > req_q.address;
  assign stat_o.hit      = (req_end <= buf_end) && ({1'b0, req_q.address} < buf_end);
  assign stat_o.free_ok  = !free_head_q[IdxW];

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  // new buffer insert target: after last scanned or at used head
  logic [IdxW-1:0] nb, lv, uh;
  logic [LinkW-1:0] nb_next;
  assign nb = fh;
  assign lv = last_vis_q[IdxW-1:0];
  assign uh = used_head_q[IdxW-1:0];
  assign nb_next = next_q[nb];

  assign finish = cmd_i.lk_hit || cmd_i.lk_miss || cmd_i.lk_full || cmd_i.tick_done;

  always_comb begin
    res_d = '0;
    if (cmd_i.lk_hit) begin
      res_d.status       = StatHit;
      res_d.buffer_index = 5'(cur);
      res_d.byte_offset  = 11'(req_q.address - start_q[cur]);
    end else if (cmd_i.lk_full) begin
      res_d.status       = StatFull;
      res_d.buffer_index = used_head_q[IdxW] ? 5'd0 : 5'(uh);
    end else if (cmd_i.lk_miss) begin
      res_d.status        = StatMiss;
      res_d.buffer_index  = 5'(nb);
      res_d.byte_offset   = {10'd0, req_q.address[0]};
      res_d.fetch_start   = 1'b1;
      res_d.fetch_address = {req_q.address[AddrW-1:1], 1'b0};
      res_d.fetch_slot    = fetch_cnt_q;
    end else if (cmd_i.tick_done) begin
      res_d.status      = StatTick;
      res_d.freed_count = 6'(freed_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBuffers; i++) begin
        next_q[i] <= (i + 1 < NumBuffers) ? LinkW'(i + 1) : Nil;
        prev_q[i] <= (i > 0) ? LinkW'(i - 1) : Nil;
      end
      used_head_q <= Nil;
      free_head_q <= '0;
      frame_q     <= '0;
      fetch_cnt_q <= '0;
      keep_q      <= 8'd2;
      strobe_q    <= 1'b0;
      cur_q       <= Nil;
      last_vis_q  <= Nil;
      guard_q     <= '0;
      freed_q     <= '0;
    end else begin
      strobe_q <= finish;
      if (finish) res_q <= res_d;
      if (cfg_we_i) keep_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        req_q      <= req_i;
        cur_q      <= used_head_q;
        last_vis_q <= Nil;
        guard_q    <= '0;
        freed_q    <= '0;
      end
      if (cmd_i.step) begin
        cur_q   <= nxt;
        guard_q <= guard_q + 1'b1;
        if (!req_q.operation) begin
          last_vis_q <= cur_q;
        end else if (aged) begin
          freed_q <= freed_q + 1'b1;
          if (used_head_q == cur_q) used_head_q <= nxt;
          // unlink from used list (prev/next of neighbors)
          if (!nxt[IdxW]) prev_q[nxt[IdxW-1:0]] <= prev_q[cur];
          if (!prev_q[cur][IdxW]) next_q[prev_q[cur][IdxW-1:0]] <= nxt;
          if (!free_head_q[IdxW]) begin
            next_q[cur] <= next_q[fh];
            prev_q[cur] <= free_head_q;
            if (!next_q[fh][IdxW]) prev_q[next_q[fh][IdxW-1:0]] <= cur_q;
            next_q[fh] <= cur_q;
          end else begin
            free_head_q <= cur_q;
            next_q[cur] <= Nil;
            prev_q[cur] <= Nil;
          end
        end
      end
      if (cmd_i.lk_hit) begin
        last_q[cur] <= frame_q;
      end
      if (cmd_i.lk_miss) begin
        free_head_q <= nb_next;
        // free head has no prev; unlinking only fixes next's prev
        if (!nb_next[IdxW]) prev_q[nb_next[IdxW-1:0]] <= Nil;
        if (!last_vis_q[IdxW]) begin
          next_q[nb] <= next_q[lv];
          prev_q[nb] <= last_vis_q;
          if (!next_q[lv][IdxW]) prev_q[next_q[lv][IdxW-1:0]] <= LinkW'(nb);
          next_q[lv] <= LinkW'(nb);
        end else if (!used_head_q[IdxW]) begin
          next_q[nb]  <= used_head_q;
          prev_q[nb]  <= Nil;
          prev_q[uh]  <= LinkW'(nb);
          used_head_q <= LinkW'(nb);
        end else begin
          used_head_q <= LinkW'(nb);
          next_q[nb]  <= Nil;
          prev_q[nb]  <= Nil;
        end
        start_q[nb] <= {req_q.address[AddrW-1:1], 1'b0};
        last_q[nb]  <= frame_q;
        if (fetch_cnt_q != 8'hff) fetch_cnt_q <= fetch_cnt_q + 1'b1;
      end
      if (cmd_i.tick_done) begin
        fetch_cnt_q <= '0;
        frame_q     <= frame_q + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_q <= CntW'(NumBuffers))
    else $error("walk guard overrun");
  a_miss_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lk_miss |-> !free_head_q[IdxW])
    else $error("miss with empty free list");
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |=> !strobe_q)
    else $error("back to back results");
`endif

endmodule
